// File: hw/rtl/urfr_pkg.sv
package urfr_pkg;

  localparam logic [2:0] ActTick     = 3'd0;
  localparam logic [2:0] ActRxByte   = 3'd1;
  localparam logic [2:0] ActSendReq  = 3'd2;
  localparam logic [2:0] ActWrDone   = 3'd3;
  localparam logic [2:0] ActHandDone = 3'd4;
  localparam logic [2:0] ActRead     = 3'd5;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWait = 2'd1;
  localparam logic [1:0] StRecv = 2'd2;

  localparam logic CfgRespTimeout = 1'b0;
  localparam logic CfgGapTicks    = 1'b1;

  localparam logic [15:0] RespTimeoutReset = 16'd1000;
  localparam logic [15:0] GapTicksReset    = 16'd10;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] rx_data;
    logic [7:0] read_index;
  } urfr_in_t;

  typedef struct packed {
    logic [1:0]  link_state;
    logic        frame_ready;
    logic        timed_out;
    logic        read_status;
    logic        timeout_status;
    logic        write_status;
    logic [8:0]  byte_count;
    logic [7:0]  read_data;
    logic [15:0] timeout_total;
    logic        transmit_start;
    logic        busy_res;
    logic        overflow;
  } urfr_out_t;

endpackage

// File: hw/rtl/urfr_ram.sv
module urfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/uart_response_frame_receiver.sv
// The result beat of an accepted input beat is registered and appears in the next cycle.
// Throughput: one beat per cycle; input is taken whenever the result register
// is empty or being drained, so the store write and read port never limit it.
// Reset: asynchronous, active low; link idle, counters and flags cleared,
// thresholds at 1000 and 10 ticks. The byte store is not cleared.
module uart_response_frame_receiver #(
  parameter int STORE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  urfr_pkg::urfr_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output urfr_pkg::urfr_out_t out_data_o
);

  import urfr_pkg::*;

  localparam int AddrW = $clog2(STORE_DEPTH);
  localparam int CntW  = $clog2(STORE_DEPTH + 1);
  localparam int CmpW  = (CntW > 8) ? CntW : 8;

  logic [15:0]     tmo_ticks_q, gap_ticks_q;
  logic [1:0]      state_q, state_d;
  logic [15:0]     tmo_cnt_q, tmo_cnt_d;
  logic [15:0]     gap_cnt_q, gap_cnt_d;
  logic            read_flag_q, read_flag_d;
  logic            tmo_flag_q, tmo_flag_d;
  logic            write_flag_q, write_flag_d;
  logic [CntW-1:0] count_q, count_d;
  logic [15:0]     err_total_q, err_total_d;

  logic            out_valid_q;
  urfr_out_t       res_q, res_d;
  logic            rd_sel_q;

  logic            accept;
  logic            ram_we, ram_re, rd_hit;
  logic [15:0]     tmo_inc, gap_inc;
  logic            tmo_hit, gap_hit;
  logic [7:0]      ram_rdata;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tmo_inc    = tmo_cnt_q + 16'd1;
  assign gap_inc    = gap_cnt_q + 16'd1;
  assign rd_hit     = (CmpW'(in_data_i.read_index) < CmpW'(count_q)) &&
                      (CmpW'(in_data_i.read_index) < CmpW'(STORE_DEPTH));

  always_comb begin
    state_d      = state_q;
    tmo_cnt_d    = tmo_cnt_q;
    gap_cnt_d    = gap_cnt_q;
    read_flag_d  = read_flag_q;
    tmo_flag_d   = tmo_flag_q;
    write_flag_d = write_flag_q;
    count_d      = count_q;
    err_total_d  = err_total_q;
    tmo_hit      = 1'b0;
    gap_hit      = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    res_d        = '0;
    case (in_data_i.action)
      ActTick: begin
        if (state_q inside {StWait, StRecv}) begin
          tmo_cnt_d = tmo_inc;
          if (tmo_inc >= tmo_ticks_q) begin
            tmo_cnt_d = '0;
            tmo_hit   = 1'b1;
          end
        end
        if (state_q == StRecv) begin
          gap_cnt_d = gap_inc;
          if (gap_inc >= gap_ticks_q) begin
            gap_cnt_d = '0;
            gap_hit   = 1'b1;
          end
        end
        if (tmo_hit) begin
          err_total_d       = err_total_q + 16'd1;
          read_flag_d       = 1'b1;
          tmo_flag_d        = 1'b1;
          count_d           = '0;
          state_d           = StIdle;
          res_d.timed_out   = 1'b1;
        end else if (gap_hit) begin
          read_flag_d       = 1'b1;
          state_d           = StIdle;
          res_d.frame_ready = 1'b1;
        end
      end
      ActRxByte: begin
        if (count_q < CntW'(STORE_DEPTH)) begin
          ram_we  = 1'b1;
          count_d = count_q + CntW'(1);
        end else begin
          res_d.overflow = 1'b1;
        end
        gap_cnt_d = '0;
        state_d   = StRecv;
      end
      ActSendReq: begin
        if (state_q == StIdle) begin
          count_d              = '0;
          tmo_cnt_d            = '0;
          gap_cnt_d            = '0;
          tmo_flag_d           = 1'b0;
          read_flag_d          = 1'b0;
          state_d              = StWait;
          res_d.transmit_start = 1'b1;
        end
      end
      ActWrDone: begin
        write_flag_d = 1'b1;
        state_d      = StWait;
      end
      ActHandDone: begin
        read_flag_d = 1'b0;
        state_d     = StIdle;
      end
      ActRead: begin
        ram_re = rd_hit;
      end
      default: begin
      end
    endcase
    res_d.link_state     = state_d;
    res_d.read_status    = read_flag_d;
    res_d.timeout_status = tmo_flag_d;
    res_d.write_status   = write_flag_d;
    res_d.byte_count     = 9'(count_d);
    res_d.timeout_total  = err_total_d;
    res_d.busy_res       = (state_d != StIdle);
  end

  urfr_ram #(
    .Width (8),
    .Depth (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && ram_we),
    .waddr_i (AddrW'(count_q)),
    .wdata_i (in_data_i.rx_data),
    .re_i    (accept && ram_re),
    .raddr_i (AddrW'(in_data_i.read_index)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_ticks_q <= RespTimeoutReset;
      gap_ticks_q <= GapTicksReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRespTimeout: tmo_ticks_q <= cfg_wdata_i;
        CfgGapTicks:    gap_ticks_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      tmo_cnt_q    <= '0;
      gap_cnt_q    <= '0;
      read_flag_q  <= 1'b0;
      tmo_flag_q   <= 1'b0;
      write_flag_q <= 1'b0;
      count_q      <= '0;
      err_total_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        state_q      <= state_d;
        tmo_cnt_q    <= tmo_cnt_d;
        gap_cnt_q    <= gap_cnt_d;
        read_flag_q  <= read_flag_d;
        tmo_flag_q   <= tmo_flag_d;
        write_flag_q <= write_flag_d;
        count_q      <= count_d;
        err_total_q  <= err_total_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q    <= res_d;
      rd_sel_q <= ram_re;
    end
  end

  always_comb begin
    out_data_o           = res_q;
    out_data_o.read_data = rd_sel_q ? ram_rdata : 8'd0;
  end

  assign out_valid_o = out_valid_q;

endmodule
